/* rtl/mfn_pkg.sv */
package mfn_pkg;

  // default datapath width of the signed fields
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FOLD,
    S_GCD,
    S_RED,
    S_DONE
  } mfn_state_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

endpackage

/* rtl/mfn_divu.sv */
module mfn_divu import mfn_pkg::*; #(
  parameter int unsigned WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-2:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-2:0] rem_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  // dividend bits shift out at the top while quotient bits shift in below
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-2:0] rem_q, rem_d;
  logic [WIDTH-2:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] shifted;
  logic [WIDTH:0]   trial;

  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[WIDTH-2:0], ~trial[WIDTH]};
      rem_d = trial[WIDTH] ? shifted[WIDTH-2:0] : trial[WIDTH-2:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q) else $error("remainder not below divisor");
`endif

endmodule

/* rtl/mfn_gcd.sv */
module mfn_gcd import mfn_pkg::*; #(
  parameter int unsigned WIDTH = DATA_WIDTH_DEF - 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             done_o,
  output logic [WIDTH-1:0] gcd_o
);

  localparam int unsigned KW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [KW-1:0]    k_q, k_d;
  logic             busy_q, busy_d;
  logic             back_q, back_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   diff;
  logic [WIDTH:0]   ndiff;

  assign diff  = {1'b0, a_q} - {1'b0, b_q};
  assign ndiff = ~diff + 1'b1;

  // binary euclid: one halving or subtract-and-halve per cycle, then the
  // common power of two is shifted back in one bit per cycle
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    busy_d = busy_q;
    back_d = back_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
      back_d = 1'b0;
    end else if (busy_q && !back_q) begin
      priority if (a_q == '0 || b_q == '0) begin
        a_d    = a_q | b_q;
        back_d = 1'b1;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (!diff[WIDTH]) begin
        a_d = {1'b0, diff[WIDTH-1:1]};
      end else begin
        b_d = {1'b0, ndiff[WIDTH-1:1]};
      end
    end else if (busy_q) begin
      if (k_q == '0) begin
        busy_d = 1'b0;
        back_d = 1'b0;
        done_d = 1'b1;
      end else begin
        a_d = {a_q[WIDTH-2:0], 1'b0};
        k_d = k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      busy_q <= 1'b0;
      back_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      k_q    <= k_d;
      busy_q <= busy_d;
      back_q <= back_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign gcd_o  = a_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("gcd started while busy");
  a_not_both_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !back_q |-> (a_q != '0 || b_q != '0)) else $error("gcd operands both zero");
  a_result_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> a_q != '0) else $error("gcd result is zero");
`endif

endmodule

/* rtl/mixed_fraction_normalizer.sv */
// mixed number normalizer: folds an improper fraction into the whole part
// and reduces the fraction by its gcd
//
// input channel: in_valid_i / in_stall_o carry whole_in_i, numer_in_i and
// denom_in_i; a transfer happens on a clock edge with valid high, stall low
// output channel: out_valid_o / out_stall_i carry whole_out_o, numer_out_o,
// denom_out_o, is_negative_o and error_code_o (0 ok, 1 zero denominator,
// 2 whole part overflow; on an error all other fields are zero)
//
// one item is worked on at a time; in_stall_o is low only while idle
// after an input transfer a zero denominator goes straight to the result
// and an overflow ends the item once the fold division is through;
// otherwise the fold division, the binary gcd and the two reduction
// divisions, which run side by side, follow in turn
// the next item can be taken in the cycle after a result is loaded
// a result sits in an output register, so the next item is taken while
// the receiver stalls; only a finished item waits for that register
// reset (rst_ni low, asynchronous) empties the block and drops out_valid_o
module mixed_fraction_normalizer import mfn_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] whole_in_i,
  input  logic signed [DATA_WIDTH-1:0] numer_in_i,
  input  logic        [DATA_WIDTH-2:0] denom_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] whole_out_o,
  output logic signed [DATA_WIDTH-1:0] numer_out_o,
  output logic        [DATA_WIDTH-2:0] denom_out_o,
  output logic                         is_negative_o,
  output logic        [1:0]            error_code_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned DW = DATA_WIDTH - 1;

  mfn_state_e state_q, state_d;

  // working registers: magnitudes, sign and error of the item in flight
  logic [W-1:0]  whole_q, whole_d;
  logic [W-1:0]  num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic          neg_q, neg_d;
  err_e          err_q, err_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  out_whole_q, out_whole_d;
  logic [W-1:0]  out_numer_q, out_numer_d;
  logic [DW-1:0] out_denom_q, out_denom_d;
  logic          out_neg_q, out_neg_d;
  err_e          out_err_q, out_err_d;

  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic [W-1:0]  whole_raw, numer_raw;
  logic [W-1:0]  whole_mag, numer_mag;
  logic [W:0]    fold_sum;
  logic          fold_ovf;
  logic [W-1:0]  whole_neg, num_neg;

  // divider 0 does the fold and later the numerator reduction,
  // divider 1 the denominator reduction alongside it
  logic          div0_start, div0_done;
  logic [DW-1:0] div0_dvs;
  logic [W-1:0]  div0_quot;
  logic [DW-1:0] div0_rem;
  logic          div1_start, div1_done;
  logic [W-1:0]  div1_quot;
  logic [DW-1:0] div1_rem;
  logic          gcd_start, gcd_done;
  logic [DW-1:0] gcd_val;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // sign and magnitude of the signed inputs; most negative gives 2^(W-1)
  assign whole_raw = whole_in_i;
  assign numer_raw = numer_in_i;
  assign whole_mag = whole_raw[W-1] ? (~whole_raw + 1'b1) : whole_raw;
  assign numer_mag = numer_raw[W-1] ? (~numer_raw + 1'b1) : numer_raw;

  // whole part after the fold; overflow if either side leaves the range
  assign fold_sum = {1'b0, whole_q} + {1'b0, div0_quot};
  assign fold_ovf = whole_q[W-1] | fold_sum[W] | fold_sum[W-1];

  assign whole_neg = ~whole_q + 1'b1;
  assign num_neg   = ~num_q + 1'b1;

  assign div0_dvs = (state_q == S_START) ? den_q : gcd_val;

  mfn_divu #(
    .WIDTH (W)
  ) u_div0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div0_start),
    .dividend_i (num_q),
    .divisor_i  (div0_dvs),
    .done_o     (div0_done),
    .quot_o     (div0_quot),
    .rem_o      (div0_rem)
  );

  mfn_divu #(
    .WIDTH (W)
  ) u_div1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div1_start),
    .dividend_i ({1'b0, den_q}),
    .divisor_i  (gcd_val),
    .done_o     (div1_done),
    .quot_o     (div1_quot),
    .rem_o      (div1_rem)
  );

  // gcd starts on the fold remainder straight from divider 0
  mfn_gcd #(
    .WIDTH (DW)
  ) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (den_q),
    .b_i     (div0_rem),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_START;
      S_START: state_d = (den_q == '0) ? S_DONE : S_FOLD;
      S_FOLD:  if (div0_done) state_d = fold_ovf ? S_DONE : S_GCD;
      S_GCD:   if (gcd_done) state_d = S_RED;
      S_RED:   if (div0_done) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div0_start = 1'b0;
    div1_start = 1'b0;
    gcd_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_START: div0_start = (den_q != '0);
      S_FOLD:  gcd_start  = div0_done && !fold_ovf;
      S_GCD: begin
        div0_start = gcd_done;
        div1_start = gcd_done;
      end
      S_RED:   ;
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  // working registers
  always_comb begin
    whole_d = whole_q;
    num_d   = num_q;
    den_d   = den_q;
    neg_d   = neg_q;
    err_d   = err_q;
    if (in_fire) begin
      whole_d = whole_mag;
      num_d   = numer_mag;
      den_d   = denom_in_i;
      neg_d   = whole_raw[W-1] | numer_raw[W-1];
      err_d   = ERR_NONE;
    end
    if (state_q == S_START && den_q == '0) begin
      err_d = ERR_ZERO_DEN;
    end
    if (state_q == S_FOLD && div0_done) begin
      if (fold_ovf) begin
        err_d = ERR_OVERFLOW;
      end else begin
        whole_d = fold_sum[W-1:0];
        num_d   = {1'b0, div0_rem};
      end
    end
    if (state_q == S_RED && div0_done) begin
      num_d = div0_quot;
      den_d = div1_quot[DW-1:0];
    end
  end

  // output register: sign on the whole part, or on the numerator if it is zero
  always_comb begin
    out_valid_d = out_load | (out_valid_q & out_stall_i);
    out_whole_d = out_whole_q;
    out_numer_d = out_numer_q;
    out_denom_d = out_denom_q;
    out_neg_d   = out_neg_q;
    out_err_d   = out_err_q;
    if (out_load) begin
      out_err_d = err_q;
      if (err_q != ERR_NONE) begin
        out_whole_d = '0;
        out_numer_d = '0;
        out_denom_d = '0;
        out_neg_d   = 1'b0;
      end else begin
        out_whole_d = neg_q ? whole_neg : whole_q;
        out_numer_d = (whole_q == '0 && neg_q) ? num_neg : num_q;
        out_denom_d = den_q;
        out_neg_d   = neg_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    whole_q     <= whole_d;
    num_q       <= num_d;
    den_q       <= den_d;
    neg_q       <= neg_d;
    err_q       <= err_d;
    out_whole_q <= out_whole_d;
    out_numer_q <= out_numer_d;
    out_denom_q <= out_denom_d;
    out_neg_q   <= out_neg_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign whole_out_o   = out_whole_q;
  assign numer_out_o   = out_numer_q;
  assign denom_out_o   = out_denom_q;
  assign is_negative_o = out_neg_q;
  assign error_code_o  = out_err_q;

`ifndef SYNTH
  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> whole_out_o == '0 && numer_out_o == '0 &&
      denom_out_o == '0 && !is_negative_o) else $error("error result carries data");
  a_denom_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_NONE |-> denom_out_o != '0)
    else $error("reduced denominator is zero");
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RED |-> div0_done == div1_done) else $error("reduction dividers out of step");
  a_div1_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RED && div1_done |-> div1_rem == '0 && div0_rem == '0)
    else $error("gcd does not divide both operands");
`endif

endmodule
